[sv/gcd_pkg.sv]
// gcd_pkg: shared types and constants of the gradient corner detector
// no dependencies; imported by every gcd module and the top level
package gcd_pkg;

  localparam int GRAD_W     = 12;   // gradient field width
  localparam int NUM_W      = 50;   // numerator: 8 terms of up to 46 bits
  localparam int DEN_W      = 27;   // denominator: 16 squares of up to 23 bits
  localparam int SCORE_W    = 32;
  localparam int THR_W      = 24;
  localparam int DIM_CFG_W  = 11;   // frame size register width
  localparam int ROW_W      = 10;
  localparam int MAX_HEIGHT = 1024;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_XY_W   = 10;
  localparam int FOUND_W    = 6;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } grad_pair_t;

  // two previous rows of one column: upper (y-2) then middle (y-1)
  typedef struct packed {
    grad_pair_t up;
    grad_pair_t mid;
  } line_entry_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
  } in_item_t;

  typedef struct packed {
    logic [OUT_XY_W-1:0] corner_x;
    logic [OUT_XY_W-1:0] corner_y;
    logic [SCORE_W-1:0]  corner_score;
    logic                entry_valid;
    logic [FOUND_W-1:0]  corners_found;
    logic                list_overflowed;
    logic                last;
  } out_item_t;

  // result handed from the score unit to the sequencer
  typedef struct packed {
    logic               is_corner;
    logic [SCORE_W-1:0] score;
  } score_res_t;

endpackage

[sv/gcd_score_unit.sv]
// gcd_score_unit: neighbour sums, threshold test and serial divider
// depends on gcd_pkg
module gcd_score_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  gcd_pkg::grad_pair_t [8:0]      win,
  input  logic [gcd_pkg::THR_W-1:0]      thr,
  output logic                           done,
  output gcd_pkg::score_res_t            res
);
  import gcd_pkg::*;

  localparam int QW    = NUM_W + 8;
  localparam int DCNT_W = $clog2(QW);
  localparam int PROD_W = THR_W + DEN_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_SUB  = 9'b000000100,
    S_SQ   = 9'b000001000,
    S_ACC  = 9'b000010000,
    S_THR  = 9'b000100000,
    S_CMP  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_FIN  = 9'b100000000
  } sstate_t;

  sstate_t state_r, state_nxt;
  logic [3:0] k_r, k_nxt;

  logic signed [2*GRAD_W-1:0] p1_r, p2_r, xx_r, yy_r;
  logic [2*GRAD_W-1:0]        dabs_r;
  logic [2*(2*GRAD_W)-1:0]    sq_r;
  logic [NUM_W-1:0]           num_r;
  logic [DEN_W-2:0]           sxx_r, syy_r;
  logic [DEN_W-1:0]           den_r;
  logic [PROD_W-1:0]          prod_r;
  logic [QW-1:0]              dvd_r;
  logic [DEN_W-1:0]           rem_r;
  logic [DCNT_W-1:0]          dcnt_r;
  logic                       corner_r;

  grad_pair_t center, nb;
  logic signed [2*GRAD_W:0]   diff;
  logic [DEN_W:0]             rem_sh;
  logic                       rem_ge;

  assign center = win[4];
  assign nb     = win[k_r];
  assign diff   = (2*GRAD_W+1)'(p1_r) - (2*GRAD_W+1)'(p2_r);
  assign rem_sh = {rem_r, dvd_r[QW-1]};
  assign rem_ge = rem_sh >= {1'b0, den_r};

  // control
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: if (start) begin
        state_nxt = S_MUL;
        k_nxt     = 4'd0;
      end
      S_MUL:  state_nxt = S_SUB;
      S_SUB:  state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ACC;
      S_ACC: begin
        if (k_r == 4'd8) begin
          state_nxt = S_THR;
        end else begin
          state_nxt = S_MUL;
          // skip the center tap
          k_nxt     = (k_r == 4'd3) ? 4'd5 : k_r + 4'd1;
        end
      end
      S_THR:  state_nxt = S_CMP;
      S_CMP: begin
        if (den_r == '0 || !(PROD_W'(num_r) > prod_r)) state_nxt = S_FIN;
        else state_nxt = S_DIV;
      end
      S_DIV:  if (dcnt_r == DCNT_W'(QW-1)) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= 4'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  // datapath: each neighbour through multiply, subtract, square and accumulate, then threshold and divide
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        num_r <= '0;
        sxx_r <= '0;
        syy_r <= '0;
      end
      S_MUL: begin
        p1_r <= center.gx * nb.gy;
        p2_r <= center.gy * nb.gx;
        xx_r <= nb.gx * nb.gx;
        yy_r <= nb.gy * nb.gy;
      end
      S_SUB: begin
        dabs_r <= diff[2*GRAD_W] ? (2*GRAD_W)'(-diff) : diff[2*GRAD_W-1:0];
        sxx_r  <= sxx_r + (DEN_W-1)'(xx_r[2*GRAD_W-2:0]);
        syy_r  <= syy_r + (DEN_W-1)'(yy_r[2*GRAD_W-2:0]);
      end
      S_SQ:  sq_r  <= dabs_r * dabs_r;
      S_ACC: begin
        num_r <= num_r + NUM_W'(sq_r);
        den_r <= DEN_W'(sxx_r) + DEN_W'(syy_r);
      end
      S_THR: prod_r <= PROD_W'(thr) * PROD_W'(den_r);
      S_CMP: begin
        corner_r <= !(den_r == '0 || !(PROD_W'(num_r) > prod_r));
        dvd_r    <= {num_r, 8'd0};
        rem_r    <= '0;
        dcnt_r   <= '0;
      end
      S_DIV: begin
        rem_r  <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        dvd_r  <= {dvd_r[QW-2:0], rem_ge};
        dcnt_r <= dcnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // result with saturation to 32 bits
  assign done          = (state_r == S_FIN);
  assign res.is_corner = corner_r;
  assign res.score     = (|dvd_r[QW-1:SCORE_W]) ? '1 : dvd_r[SCORE_W-1:0];

endmodule

[sv/gcd_corner_list.sv]
// gcd_corner_list: score-sorted corner list in a synchronous memory, insert and dump
// depends on gcd_pkg
module gcd_corner_list #(
  parameter int LIST_DEPTH = 32,
  parameter int COL_W      = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ins_start,
  input  logic [COL_W-1:0]              ins_x,
  input  logic [gcd_pkg::ROW_W-1:0]     ins_y,
  input  logic [gcd_pkg::SCORE_W-1:0]   ins_score,
  input  logic                          dump_start,
  output logic                          done,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gcd_pkg::out_item_t            out_data
);
  import gcd_pkg::*;

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int EW    = COL_W + ROW_W + SCORE_W;

  typedef enum logic [6:0] {
    L_IDLE = 7'b0000001,
    L_FCHK = 7'b0000010,
    L_STEP = 7'b0000100,
    L_WAIT = 7'b0001000,
    L_DRD  = 7'b0010000,
    L_DLD  = 7'b0100000,
    L_OUT  = 7'b1000000
  } lstate_t;

  logic [EW-1:0] mem [LIST_DEPTH];
  logic [EW-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  lstate_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, di_r, di_nxt;
  logic [EW-1:0]    new_r, new_nxt;
  out_item_t        out_r, out_nxt;
  logic             valid_r, valid_nxt;
  logic             rd_ge;

  assign rd_ge = rd_q[SCORE_W-1:0] >= new_r[SCORE_W-1:0];

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    di_nxt    = di_r;
    new_nxt   = new_r;
    out_nxt   = out_r;
    valid_nxt = valid_r;
    rd_addr   = '0;
    wr_addr   = i_r;
    wr_data   = new_r;
    wr_en     = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      L_IDLE: begin
        if (ins_start) begin
          new_nxt = {ins_x, ins_y, ins_score};
          if (cnt_r == CNT_W'(LIST_DEPTH)) begin
            // full: look at the weakest entry first
            ovf_nxt   = 1'b1;
            rd_addr   = IDX_W'(LIST_DEPTH - 1);
            state_nxt = L_FCHK;
          end else begin
            i_nxt     = cnt_r[IDX_W-1:0];
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = L_STEP;
          end
        end else if (dump_start) begin
          if (cnt_r == '0) begin
            out_nxt                 = '0;
            out_nxt.list_overflowed = ovf_r;
            out_nxt.last            = 1'b1;
            valid_nxt               = 1'b1;
            state_nxt               = L_OUT;
          end else begin
            di_nxt    = '0;
            state_nxt = L_DRD;
          end
        end
      end
      L_FCHK: begin
        if (rd_ge) begin
          done      = 1'b1;
          state_nxt = L_IDLE;
        end else begin
          i_nxt     = IDX_W'(LIST_DEPTH - 1);
          state_nxt = L_STEP;
        end
      end
      // walk down from the free slot, moving weaker entries up one place
      L_STEP: begin
        if (i_r == '0) begin
          wr_en     = 1'b1;
          done      = 1'b1;
          state_nxt = L_IDLE;
        end else begin
          rd_addr   = i_r - 1'b1;
          state_nxt = L_WAIT;
        end
      end
      L_WAIT: begin
        wr_en = 1'b1;
        if (rd_ge) begin
          done      = 1'b1;
          state_nxt = L_IDLE;
        end else begin
          wr_data   = rd_q;
          i_nxt     = i_r - 1'b1;
          state_nxt = L_STEP;
        end
      end
      L_DRD: begin
        rd_addr   = di_r;
        state_nxt = L_DLD;
      end
      L_DLD: begin
        out_nxt.corner_x        = OUT_XY_W'(rd_q[EW-1 -: COL_W]);
        out_nxt.corner_y        = rd_q[SCORE_W +: ROW_W];
        out_nxt.corner_score    = rd_q[SCORE_W-1:0];
        out_nxt.entry_valid     = 1'b1;
        out_nxt.corners_found   = FOUND_W'(cnt_r);
        out_nxt.list_overflowed = ovf_r;
        out_nxt.last            = (CNT_W'(di_r) == cnt_r - 1'b1);
        valid_nxt               = 1'b1;
        state_nxt               = L_OUT;
      end
      // hold the result until the transfer
      L_OUT: begin
        if (!out_stall) begin
          valid_nxt = 1'b0;
          if (out_r.last) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            done      = 1'b1;
            state_nxt = L_IDLE;
          end else begin
            di_nxt    = di_r + 1'b1;
            state_nxt = L_DRD;
          end
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    di_r  <= di_nxt;
    new_r <= new_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule

[sv/gradient_corner_detector.sv]
// gradient_corner_detector: top level, line store, 3x3 window and pixel sequencer
// depends on gcd_pkg, gcd_score_unit and gcd_corner_list
//
// Usage: gradient pairs enter in raster order on in_valid/in_stall/in_data,
// one transfer per pixel, one pixel at a time. Frame size and score threshold
// are written on cfg_we/cfg_index/cfg_data; the user must do so only while
// the block is idle, which the block itself does not enforce.
// An evaluated center takes its eight neighbours in turn through the shared
// multipliers, then the threshold test; a center that passes goes through
// the one-bit-per-cycle divider. Its insert moves each weaker entry one place
// further back in the list memory; when the list is full its weakest entry
// is compared first, and a corner no stronger than it is dropped. The last
// pixel of a frame dumps the list on out_valid/out_stall/out_data, entry by
// entry, or one entry with entry_valid low for an empty list. While the
// receiver stalls the result holds and no pixel is taken. After reset the
// line store is cleared, one column per cycle over all MAX_WIDTH columns,
// while in_stall stays high; configuration writes are taken.
module gradient_corner_detector #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LIST_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gcd_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gcd_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [gcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gcd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int DIM_W = (COL_W + 1 > DIM_CFG_W) ? COL_W + 1 : DIM_CFG_W;

  typedef enum logic [5:0] {
    T_CLR   = 6'b000001,
    T_IDLE  = 6'b000010,
    T_LINE  = 6'b000100,
    T_SCORE = 6'b001000,
    T_INS   = 6'b010000,
    T_DUMP  = 6'b100000
  } tstate_t;

  tstate_t state_r, state_nxt;

  // configuration registers
  logic [DIM_CFG_W-1:0] fw_r, fh_r;
  logic [THR_W-1:0]     thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= DIM_CFG_W'(640);
      fh_r  <= DIM_CFG_W'(480);
      thr_r <= THR_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r  <= cfg_data[DIM_CFG_W-1:0];
        CFG_FRAME_HEIGHT: fh_r  <= cfg_data[DIM_CFG_W-1:0];
        CFG_THRESHOLD:    thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position and per-pixel decisions
  logic [COL_W-1:0] col_r, clr_r, pix_col_r, cx_r;
  logic [ROW_W-1:0] row_r, cy_r;
  logic             eval_r, fend_r;
  grad_pair_t       pix_r;
  logic [DIM_W-1:0] w_eff, h_eff, xe, ye, fw_e, fh_e;
  logic             acc, eval_c, row_end, frame_end;

  assign fw_e  = DIM_W'(fw_r);
  assign fh_e  = DIM_W'(fh_r);
  assign w_eff = (fw_e < DIM_W'(4)) ? DIM_W'(4) :
                 (fw_e > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_e;
  assign h_eff = (fh_e < DIM_W'(4)) ? DIM_W'(4) :
                 (fh_e > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_e;
  assign xe    = DIM_W'(col_r);
  assign ye    = DIM_W'(row_r);
  assign eval_c    = (xe >= DIM_W'(2)) && (ye >= DIM_W'(2)) &&
                     (xe + DIM_W'(3) <= w_eff) && (ye + DIM_W'(3) <= h_eff);
  assign row_end   = (xe + DIM_W'(1) >= w_eff);
  assign frame_end = row_end && (ye + DIM_W'(1) >= h_eff);

  assign in_stall = (state_r != T_IDLE);
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      clr_r <= '0;
    end else begin
      if (state_r == T_CLR) clr_r <= clr_r + 1'b1;
      if (acc) begin
        col_r <= row_end ? '0 : col_r + 1'b1;
        if (row_end) row_r <= frame_end ? '0 : row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pix_r.gx  <= in_data.grad_x;
      pix_r.gy  <= in_data.grad_y;
      pix_col_r <= col_r;
      cx_r      <= col_r - 1'b1;
      cy_r      <= row_r - 1'b1;
      eval_r    <= eval_c;
      fend_r    <= frame_end;
    end
  end

  // line store: two previous rows per column, registered read
  line_entry_t ls_mem [MAX_WIDTH];
  line_entry_t ls_q, ls_wd;
  logic [COL_W-1:0] ls_wa;
  logic             ls_we;

  always_comb begin
    ls_we     = 1'b0;
    ls_wa     = pix_col_r;
    ls_wd.up  = ls_q.mid;
    ls_wd.mid = pix_r;
    if (state_r == T_CLR) begin
      ls_we = 1'b1;
      ls_wa = clr_r;
      ls_wd = '0;
    end else if (state_r == T_LINE) begin
      ls_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ls_we) ls_mem[ls_wa] <= ls_wd;
    ls_q <= ls_mem[col_r];
  end

  // 3x3 window, index row*3+col, newest column on the right
  grad_pair_t [8:0] win_r;

  always_ff @(posedge clk) begin
    if (state_r == T_LINE) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= ls_q.up;
      win_r[5] <= ls_q.mid;
      win_r[8] <= pix_r;
    end
  end

  // score unit and corner list
  logic       sc_start, sc_done, ls_start_ins, ls_start_dump, lst_done;
  score_res_t sc_res;

  gcd_score_unit u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .win   (win_r),
    .thr   (thr_r),
    .done  (sc_done),
    .res   (sc_res)
  );

  gcd_corner_list #(
    .LIST_DEPTH (LIST_DEPTH),
    .COL_W      (COL_W)
  ) u_list (
    .clk        (clk),
    .rst_n      (rst_n),
    .ins_start  (ls_start_ins),
    .ins_x      (cx_r),
    .ins_y      (cy_r),
    .ins_score  (sc_res.score),
    .dump_start (ls_start_dump),
    .done       (lst_done),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // pixel sequencer
  always_comb begin
    state_nxt     = state_r;
    sc_start      = 1'b0;
    ls_start_ins  = 1'b0;
    ls_start_dump = 1'b0;
    unique case (state_r)
      T_CLR:  if (clr_r == COL_W'(MAX_WIDTH - 1)) state_nxt = T_IDLE;
      T_IDLE: if (acc) state_nxt = T_LINE;
      T_LINE: begin
        if (eval_r) begin
          sc_start  = 1'b1;
          state_nxt = T_SCORE;
        end else if (fend_r) begin
          ls_start_dump = 1'b1;
          state_nxt     = T_DUMP;
        end else begin
          state_nxt = T_IDLE;
        end
      end
      T_SCORE: begin
        if (sc_done) begin
          if (sc_res.is_corner) begin
            ls_start_ins = 1'b1;
            state_nxt    = T_INS;
          end else if (fend_r) begin
            ls_start_dump = 1'b1;
            state_nxt     = T_DUMP;
          end else begin
            state_nxt = T_IDLE;
          end
        end
      end
      T_INS: begin
        if (lst_done) begin
          if (fend_r) begin
            ls_start_dump = 1'b1;
            state_nxt     = T_DUMP;
          end else begin
            state_nxt = T_IDLE;
          end
        end
      end
      T_DUMP: if (lst_done) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= T_CLR;
    else        state_r <= state_nxt;
  end

endmodule

[tb/sv/tb.sv]
// tb: self-checking testbench for the gradient corner detector
// depends on gcd_pkg and gradient_corner_detector; predicts every list dump
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcd_pkg::*;

  localparam int MAX_COLS    = 1024;
  localparam int LIST_SLOTS  = 32;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 400;

  // predictor of the corner list, holds expected dump entries
  class corner_scoreboard;
    int unsigned fw, fh, thr;
    int lux[MAX_COLS], luy[MAX_COLS], lmx[MAX_COLS], lmy[MAX_COLS];
    int wgx[3][3], wgy[3][3];
    int unsigned col, row;
    int unsigned lx[$], ly[$], ls[$];
    bit overflow;
    out_item_t expected_dump[$];
    int failures;

    function new();
      fw = 640; fh = 480; thr = 1000;
      for (int i = 0; i < MAX_COLS; i++) begin
        lux[i] = 0; luy[i] = 0; lmx[i] = 0; lmy[i] = 0;
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          wgx[r][c] = 0; wgy[r][c] = 0;
        end
      col = 0; row = 0; overflow = 0; failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH:  fw = val[DIM_CFG_W-1:0];
        CFG_FRAME_HEIGHT: fh = val[DIM_CFG_W-1:0];
        CFG_THRESHOLD:    thr = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(int unsigned v);
      if (v < 4) return 4;
      if (v > MAX_COLS) return MAX_COLS;
      return v;
    endfunction

    // sorted insert, equal scores go behind
    function void add_corner(int unsigned cx, int unsigned cy, int unsigned sc);
      int unsigned p;
      p = 0;
      while (p < lx.size() && ls[p] >= sc) p++;
      if (lx.size() >= LIST_SLOTS) begin
        overflow = 1;
        if (p >= LIST_SLOTS) return;
        void'(lx.pop_back()); void'(ly.pop_back()); void'(ls.pop_back());
      end
      lx.insert(p, cx); ly.insert(p, cy); ls.insert(p, sc);
    endfunction

    // corner response of the window center
    function void score_center(int unsigned cx, int unsigned cy);
      longint gx, gy, nx, ny, d;
      longint unsigned sxx, syy, num, den, q, ad;
      gx = wgx[1][1]; gy = wgy[1][1];
      sxx = 0; syy = 0; num = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          if (r == 1 && c == 1) continue;
          nx = wgx[r][c]; ny = wgy[r][c];
          sxx += nx * nx;
          syy += ny * ny;
          d = gx * ny - gy * nx;
          ad = (d < 0) ? -d : d;
          num += ad * ad;
        end
      den = sxx + syy;
      if (den == 0) return;
      if (!(num > longint'(thr) * den)) return;
      q = (num << 8) / den;
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
      add_corner(cx, cy, q[31:0]);
    endfunction

    function void note_pixel(in_item_t px);
      int unsigned w, h, x, y, cnt;
      out_item_t o;
      w = clamp_size(fw); h = clamp_size(fh);
      x = (col >= MAX_COLS) ? MAX_COLS - 1 : col;
      y = row;
      for (int r = 0; r < 3; r++) begin
        wgx[r][0] = wgx[r][1]; wgy[r][0] = wgy[r][1];
        wgx[r][1] = wgx[r][2]; wgy[r][1] = wgy[r][2];
      end
      wgx[0][2] = lux[x]; wgy[0][2] = luy[x];
      wgx[1][2] = lmx[x]; wgy[1][2] = lmy[x];
      wgx[2][2] = int'(px.grad_x); wgy[2][2] = int'(px.grad_y);
      lux[x] = lmx[x]; luy[x] = lmy[x];
      lmx[x] = int'(px.grad_x); lmy[x] = int'(px.grad_y);
      if (x >= 2 && y >= 2 && x - 1 <= w - 4 && y - 1 <= h - 4)
        score_center(x - 1, y - 1);
      if (x >= w - 1) begin
        col = 0;
        if (y >= h - 1) begin
          row = 0;
          cnt = lx.size();
          if (cnt == 0) begin
            o = '0;
            o.list_overflowed = overflow;
            o.last = 1'b1;
            expected_dump.push_back(o);
          end else begin
            for (int unsigned i = 0; i < cnt; i++) begin
              o.corner_x = OUT_XY_W'(lx[i]);
              o.corner_y = OUT_XY_W'(ly[i]);
              o.corner_score = ls[i];
              o.entry_valid = 1'b1;
              o.corners_found = FOUND_W'(cnt);
              o.list_overflowed = overflow;
              o.last = (i + 1 == cnt);
              expected_dump.push_back(o);
            end
          end
          lx.delete(); ly.delete(); ls.delete();
          overflow = 0;
        end else begin
          row = y + 1;
        end
      end else begin
        col = x + 1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_dump.size() == 0) begin
        $error("unexpected result transfer x=%0d y=%0d", got.corner_x, got.corner_y);
        failures++;
        return;
      end
      e = expected_dump.pop_front();
      if (got.corner_x !== e.corner_x) begin
        $error("corner_x expected %0d actual %0d", e.corner_x, got.corner_x); failures++;
      end
      if (got.corner_y !== e.corner_y) begin
        $error("corner_y expected %0d actual %0d", e.corner_y, got.corner_y); failures++;
      end
      if (got.corner_score !== e.corner_score) begin
        $error("corner_score expected %0d actual %0d", e.corner_score, got.corner_score);
        failures++;
      end
      if (got.entry_valid !== e.entry_valid) begin
        $error("entry_valid expected %0d actual %0d", e.entry_valid, got.entry_valid);
        failures++;
      end
      if (got.corners_found !== e.corners_found) begin
        $error("corners_found expected %0d actual %0d", e.corners_found, got.corners_found);
        failures++;
      end
      if (got.list_overflowed !== e.list_overflowed) begin
        $error("list_overflowed expected %0d actual %0d", e.list_overflowed,
               got.list_overflowed);
        failures++;
      end
      if (got.last !== e.last) begin
        $error("last expected %0d actual %0d", e.last, got.last); failures++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pixels_sent = 0;
  int unsigned cycles = 0;
  corner_scoreboard sb = new();

  gradient_corner_detector dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  // result transfers
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_pixel(in_item_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = px;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(px);
    pixels_sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  // hold off until the dump is complete and the block settles
  task automatic wait_drained();
    wait (sb.expected_dump.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_item_t rand_pixel(int flavor);
    in_item_t px;
    case (flavor)
      0: begin
        px.grad_x = GRAD_W'($urandom_range(0, 4095));
        px.grad_y = GRAD_W'($urandom_range(0, 4095));
      end
      1: begin
        px.grad_x = GRAD_W'($urandom_range(0, 6) - 3);
        px.grad_y = GRAD_W'($urandom_range(0, 6) - 3);
      end
      default: begin
        px.grad_x = GRAD_W'($urandom_range(0, 2) - 1);
        px.grad_y = GRAD_W'($urandom_range(0, 2) - 1);
      end
    endcase
    return px;
  endfunction

  task automatic run_frame(int unsigned w, int unsigned h, int unsigned thr, int flavor);
    int unsigned n;
    wait_drained();
    write_cfg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_cfg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_cfg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    n = sb.clamp_size(w[DIM_CFG_W-1:0]) * sb.clamp_size(h[DIM_CFG_W-1:0]);
    for (int unsigned i = 0; i < n; i++) send_pixel(rand_pixel(flavor));
  endtask

  task automatic random_frames(int quota);
    int start;
    int unsigned thr;
    start = pixels_sent;
    while (pixels_sent - start < quota) begin
      case ($urandom_range(0, 3))
        0: thr = 0;
        1: thr = $urandom_range(0, 50);
        2: thr = $urandom_range(0, 24'hFF_FFFF);
        default: thr = $urandom_range(0, 2000);
      endcase
      run_frame($urandom_range(4, 12), $urandom_range(4, 10), thr, $urandom_range(0, 2));
    end
  endtask

  initial begin
    in_item_t px;
    int signed corner_vals[5] = '{-2048, 2047, 0, -1, 1};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: one evaluated center, extreme gradients
    write_cfg(CFG_FRAME_WIDTH, 5);
    write_cfg(CFG_FRAME_HEIGHT, 5);
    write_cfg(CFG_THRESHOLD, 0);
    for (int i = 0; i < 25; i++) begin
      px.grad_x = GRAD_W'(corner_vals[i % 5]);
      px.grad_y = GRAD_W'(corner_vals[(i * 3 + 1) % 5]);
      send_pixel(px);
    end

    // receiver idles more than sender
    send_idle_pct = 32; recv_idle_pct = 68;
    run_frame(4, 4, 0, 0);                  // no centers: empty list
    run_frame(10, 10, 0, 0);                // more centers than list slots
    run_frame(8, 8, 24'h80_0000, 0);        // threshold with only the top bit set
    random_frames(40);

    // sender idles more than receiver
    send_idle_pct = 68; recv_idle_pct = 32;
    run_frame(10, 10, 0, 2);                // ties in a full list
    random_frames(40);

    // shrink the frame while the position is past the new edges
    wait_drained();
    write_cfg(CFG_FRAME_WIDTH, 8);
    write_cfg(CFG_FRAME_HEIGHT, 8);
    write_cfg(CFG_THRESHOLD, 0);
    for (int i = 0; i < 53; i++) send_pixel(rand_pixel(0));
    repeat (SETTLE) @(posedge clk);
    write_cfg(CFG_FRAME_WIDTH, 5);
    write_cfg(CFG_FRAME_HEIGHT, 5);
    send_pixel(rand_pixel(0));

    // no idling, then sizes below the minimum
    send_idle_pct = 0; recv_idle_pct = 0;
    random_frames(40);
    run_frame(0, 0, 1, 0);                  // both sizes clamp to the minimum
    run_frame(2, 3, 0, 1);

    wait (sb.expected_dump.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (sb.failures == 0 && sb.expected_dump.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
